>>> design/ism_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// shared types for the interval sort and merge block
// ----------------------------------------------------------------------------
package ism_pkg;

  typedef struct packed {
    logic signed [31:0] interval_start;
    logic signed [31:0] interval_end;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] merged_start;
    logic signed [31:0] merged_end;
    logic               last_out;
    logic               overflowed;
  } out_word_t;

  // sorted entry handed from the sorter to the merger
  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] e;
    logic               last;
    logic               ovf;
  } ent_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN
  } sort_state_e;

  // signed (start, end) order
  function automatic logic key_gt(input logic signed [31:0] as, input logic signed [31:0] ae,
                                  input logic signed [31:0] bs, input logic signed [31:0] be);
    key_gt = (as > bs) || ((as == bs) && (ae > be));
  endfunction

endpackage
`default_nettype wire

>>> design/ism_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_if
// valid/ready channels carrying one input word or one output word
// ----------------------------------------------------------------------------
interface ism_in_if;
  logic              valid;
  logic              ready;
  ism_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ism_out_if;
  logic               valid;
  logic               ready;
  ism_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/interval_sort_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_sort_merge
// sorts a set of closed intervals and emits the merged intervals in order
// ----------------------------------------------------------------------------
// channel | dir | word
// in_i    | in  | interval_start, interval_end, last_in
// out_o   | out | merged_start, merged_end, last_out, overflowed
//
// loading takes one word a cycle into the insertion cell chain
// after the last word the chain drains one entry a cycle, while the queue
// has room, through the queue into the merger; the final merged word is
// written when the merger takes the last entry, or after it when that entry
// opens a new run; a break or last entry stalls the merger while an earlier
// merged result still waits on the output; no input is taken while the chain
// drains; reset empties the chain at once
// ----------------------------------------------------------------------------
module interval_sort_merge #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ism_in_if.sink    in_i,
  ism_out_if.source out_o
);
  logic          sv, sr, mv, mr;
  ism_pkg::ent_t se, me;

  ism_sorter #(.N(MAX_INTERVALS)) u_sort (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .in_data_i(in_i.data),
    .ent_valid_o(sv), .ent_ready_i(sr), .ent_o(se)
  );

  ism_fifo u_q (
    .clk_i, .rst_ni,
    .wr_valid_i(sv), .wr_ready_o(sr), .wr_data_i(se),
    .rd_valid_o(mv), .rd_ready_i(mr), .rd_data_o(me)
  );

  ism_merger u_merge (
    .clk_i, .rst_ni,
    .ent_valid_i(mv), .ent_ready_o(mr), .ent_i(me), .out_o(out_o)
  );
endmodule
`default_nettype wire

>>> design/ism_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_sorter
// insertion-sorting cell chain: loads one interval a cycle, then shifts the
// sorted set out from the head, while the reader is ready, one entry a cycle
// ----------------------------------------------------------------------------
module ism_sorter #(
  parameter int unsigned N = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ism_pkg::in_word_t in_data_i,
  output logic                   ent_valid_o,
  input  wire logic              ent_ready_i,
  output ism_pkg::ent_t          ent_o
);
  localparam int unsigned CW = $clog2(N + 1);

  logic signed [31:0] s_q [N];
  logic signed [31:0] e_q [N];
  logic [N-1:0]       v_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  ism_pkg::sort_state_e st_q, st_d;

  logic acc, full, pop;
  logic [N-1:0] gt;

  assign full = (cnt_q == CW'(N));
  assign in_ready_o = (st_q == ism_pkg::ST_LOAD);
  assign acc = in_valid_i && in_ready_o;
  assign ent_valid_o = (st_q == ism_pkg::ST_DRAIN);
  assign pop = ent_valid_o && ent_ready_i;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = v_q[i] && ism_pkg::key_gt(s_q[i], e_q[i],
                                       in_data_i.interval_start, in_data_i.interval_end);
    end
  end

  assign ent_o.s    = s_q[0];
  assign ent_o.e    = e_q[0];
  assign ent_o.last = (cnt_q == CW'(1));
  assign ent_o.ovf  = ovf_q;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    case (st_q)
      ism_pkg::ST_LOAD: begin
        if (acc) begin
          if (full) ovf_d = 1'b1;
          else cnt_d = cnt_q + CW'(1);
          if (in_data_i.last_in) st_d = ism_pkg::ST_DRAIN;
        end
      end
      ism_pkg::ST_DRAIN: begin
        if (pop) begin
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            st_d  = ism_pkg::ST_LOAD;
            ovf_d = 1'b0;
          end
        end
      end
      default: st_d = ism_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ism_pkg::ST_LOAD;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      v_q   <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      if (acc && !full) begin
        for (int i = 0; i < N; i++) begin
          // cell takes the new word if it is the first greater or first empty
          if (i == 0) v_q[i] <= 1'b1;
          else if (!v_q[i] && v_q[i-1]) v_q[i] <= 1'b1;
        end
      end else if (pop) begin
        v_q <= v_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !full) begin
      for (int i = 0; i < N; i++) begin
        if (i == 0) begin
          if (gt[0] || !v_q[0]) begin
            s_q[0] <= in_data_i.interval_start;
            e_q[0] <= in_data_i.interval_end;
          end
        end else if (gt[i-1]) begin
          s_q[i] <= s_q[i-1];
          e_q[i] <= e_q[i-1];
        end else if (gt[i] || !v_q[i]) begin
          s_q[i] <= in_data_i.interval_start;
          e_q[i] <= in_data_i.interval_end;
        end
      end
    end else if (pop) begin
      for (int i = 0; i < N - 1; i++) begin
        s_q[i] <= s_q[i+1];
        e_q[i] <= e_q[i+1];
      end
    end
  end
endmodule
`default_nettype wire

>>> design/ism_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_fifo
// two-entry queue between the sorter and the merger
// ----------------------------------------------------------------------------
module ism_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire ism_pkg::ent_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output ism_pkg::ent_t      rd_data_o
);
  ism_pkg::ent_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

>>> design/ism_merger.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_merger
// folds sorted intervals into merged runs, with an output register
// ----------------------------------------------------------------------------
module ism_merger (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ent_valid_i,
  output logic               ent_ready_o,
  input  wire ism_pkg::ent_t ent_i,
  ism_out_if.source          out_o
);
  logic               have_q;
  logic signed [31:0] cs_q, ce_q;
  logic               ov_q;
  ism_pkg::out_word_t od_q;
  logic               ov_valid_q;
  logic               fin_q;
  logic take, brk, slot, emit;

  // an output slot is free when empty or being taken
  assign slot = !ov_valid_q || out_o.ready;
  assign brk  = have_q && (ce_q < ent_i.s);
  // a break or a last entry writes the output register
  assign ent_ready_o = !fin_q && (slot || !(brk || ent_i.last));
  assign take = ent_valid_i && ent_ready_o;
  // a last entry that opens a new run leaves that run pending for one more word
  assign emit = fin_q ? slot : (take && (brk || ent_i.last));
  assign out_o.valid = ov_valid_q;
  assign out_o.data  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      ov_valid_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      ov_valid_q <= emit || (ov_valid_q && !out_o.ready);
      if (fin_q) begin
        if (slot) begin
          fin_q  <= 1'b0;
          have_q <= 1'b0;
        end
      end else if (take) begin
        have_q <= !ent_i.last || brk;
        fin_q  <= brk && ent_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      if (slot) begin
        od_q.merged_start <= cs_q; od_q.merged_end <= ce_q;
        od_q.last_out <= 1'b1; od_q.overflowed <= ov_q;
      end
    end else if (take) begin
      ov_q <= ent_i.ovf;
      if (!have_q || brk) begin
        cs_q <= ent_i.s; ce_q <= ent_i.e;
      end else if (ce_q < ent_i.e) begin
        ce_q <= ent_i.e;
      end
      if (brk) begin
        od_q.merged_start <= cs_q; od_q.merged_end <= ce_q;
        od_q.last_out <= 1'b0; od_q.overflowed <= ov_q;
      end else if (ent_i.last) begin
        od_q.merged_start <= have_q ? cs_q : ent_i.s;
        od_q.merged_end   <= (have_q && !(ce_q < ent_i.e)) ? ce_q : ent_i.e;
        od_q.last_out     <= 1'b1;
        od_q.overflowed   <= ent_i.ovf;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/ism_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_checker
// port-level checks on the interval sort and merge block
// ----------------------------------------------------------------------------
module ism_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               in_last_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire ism_pkg::out_word_t out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  // closing word stops loading
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken right after the closing word");

  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid in reset");
endmodule

bind interval_sort_merge ism_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready), .in_last_i(in_i.data.last_in),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);
`default_nettype wire
